[rtl/core/rcsfd_pkg.sv]
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared types and constants of the rc satellite frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcsfd_pkg;

  localparam int FRAME_LEN_DEF    = 16;
  localparam int NUM_CHANNELS_DEF = 7;
  localparam int OUT_CHANS        = 7;

  localparam int BYTE_W  = 8;
  localparam int STAMP_W = 32;
  localparam int VALUE_W = 10;
  localparam int ID_W    = 4;
  localparam int GAP_W   = 8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_GAP  = CFG_IDX_W'(1);

  localparam logic [GAP_W-1:0] FRAME_GAP_RST = 8'd5;
  localparam logic [GAP_W-1:0] LOSS_GAP_RST  = 8'd24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } dec_state_t;

endpackage

`default_nettype wire

[rtl/core/rc_satellite_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// rc_satellite_frame_decoder_core
// Byte-stream decoder for 16-byte satellite receiver frames, 1024-step values.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries rx_byte with its now_ms timestamp.
//   out channel (out_valid/out_ready) gives one result per byte: the seven
//   channel values after that byte, frame_done and gap_error.
//   cfg channel (cfg_valid/cfg_ready, always ready) writes frame_gap_ms at
//   index 0 and loss_gap_ms at index 1; other indexes are dropped.
// Flow:
//   a byte that does not end a frame gives its registered result in the cycle
//   after its transfer; a new byte is taken in the same cycle its result is taken.
//   the frame-final byte gives its result after ST_READ and then ST_DRAIN decode
//   the frame: the frame memory has two registered read ports, so one 16-bit word
//   is decoded per cycle; no new byte is taken until that result is taken.
// Reset:
//   synchronous; channel values, byte position and last timestamp clear,
//   thresholds return to 5 and 24 ms. The frame memory is not cleared.
// Stall:
//   while a result waits, in_ready stays low and the outputs hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc_satellite_frame_decoder_core
  import rcsfd_pkg::*;
#(
  parameter int FRAME_LEN    = FRAME_LEN_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [GAP_W-1:0]     cfg_data,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    rx_byte,
  input  wire logic [STAMP_W-1:0]   now_ms,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [VALUE_W-1:0]        chan0,
  output logic [VALUE_W-1:0]        chan1,
  output logic [VALUE_W-1:0]        chan2,
  output logic [VALUE_W-1:0]        chan3,
  output logic [VALUE_W-1:0]        chan4,
  output logic [VALUE_W-1:0]        chan5,
  output logic [VALUE_W-1:0]        chan6,
  output logic                      frame_done,
  output logic                      gap_error
);

  localparam int AW     = $clog2(FRAME_LEN);
  localparam int NWORDS = (FRAME_LEN - 2) / 2;
  localparam int WCW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  logic [GAP_W-1:0]   frame_gap_ms;
  logic [GAP_W-1:0]   loss_gap_ms;
  logic [AW-1:0]      byte_pos;
  logic [STAMP_W-1:0] last_stamp;
  logic [VALUE_W-1:0] channel_store [NUM_CHANNELS];

  logic [BYTE_W-1:0]  frame_mem [FRAME_LEN];
  logic [BYTE_W-1:0]  rd_hi;
  logic [BYTE_W-1:0]  rd_lo;
  logic               rd_pending;

  dec_state_t         state;
  dec_state_t         state_next;
  logic [WCW-1:0]     wcnt;
  logic               rd_issue;
  logic               done_q;
  logic               err_q;

  logic               in_xfer;
  logic               out_xfer;
  logic [STAMP_W-1:0] gap;
  logic               restart;
  logic               err;
  logic [AW-1:0]      pos;
  logic               last_byte;
  logic [AW-1:0]      rd_addr_hi;
  logic [AW-1:0]      rd_addr_lo;
  logic [ID_W-1:0]    word_id;
  logic [VALUE_W-1:0] word_value;
  logic [VALUE_W-1:0] chan_arr [OUT_CHANS];

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign gap       = now_ms - last_stamp;
  assign restart   = gap > STAMP_W'(frame_gap_ms);
  assign err       = restart && (last_stamp != '0) && (gap > STAMP_W'(loss_gap_ms));
  assign pos       = restart ? '0 : byte_pos;
  assign last_byte = (32'(pos) == FRAME_LEN - 1);

  assign rd_addr_hi = AW'((32'(wcnt) << 1) + 32'd2);
  assign rd_addr_lo = rd_addr_hi | AW'(1);

  assign word_id    = rd_hi[BYTE_W-3 -: ID_W];
  assign word_value = {rd_hi[1:0], rd_lo};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_issue   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready && last_byte) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_issue = 1'b1;
        if (32'(wcnt) == NWORDS - 1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // frame memory, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      frame_mem[pos] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_hi <= frame_mem[rd_addr_hi];
    rd_lo <= frame_mem[rd_addr_lo];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_gap_ms <= FRAME_GAP_RST;
      loss_gap_ms  <= LOSS_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FRAME_GAP) begin
        frame_gap_ms <= cfg_data;
      end
      if (cfg_index == CFG_LOSS_GAP) begin
        loss_gap_ms <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      last_stamp <= '0;
      wcnt       <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
      done_q     <= 1'b0;
      err_q      <= 1'b0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        channel_store[k] <= '0;
      end
    end else begin
      rd_pending <= rd_issue;
      if ((state == ST_DRAIN) || (in_xfer && !last_byte)) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      if (in_xfer) begin
        last_stamp <= now_ms;
        err_q      <= err;
        done_q     <= last_byte;
        wcnt       <= '0;
        if (last_byte) begin
          byte_pos <= '0;
        end else begin
          byte_pos <= pos + AW'(1);
        end
      end
      if (rd_issue) begin
        wcnt <= wcnt + WCW'(1);
      end
      // later words overwrite earlier ones in issue order
      if (rd_pending) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          if (word_id == ID_W'(k)) begin
            channel_store[k] <= word_value;
          end
        end
      end
    end
  end

  for (genvar g = 0; g < OUT_CHANS; g++) begin : g_chan
    if (g < NUM_CHANNELS) begin : g_live
      assign chan_arr[g] = channel_store[g];
    end else begin : g_zero
      assign chan_arr[g] = '0;
    end
  end

  assign chan0      = chan_arr[0];
  assign chan1      = chan_arr[1];
  assign chan2      = chan_arr[2];
  assign chan3      = chan_arr[3];
  assign chan4      = chan_arr[4];
  assign chan5      = chan_arr[5];
  assign chan6      = chan_arr[6];
  assign frame_done = done_q;
  assign gap_error  = err_q;

  // no result is shown while a frame is being decoded
  a_no_out_in_decode: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid)
    else $error("result valid during frame decode");

  // channel values hold while a result waits
  a_chan_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(chan0) && $stable(chan3) && $stable(chan6)))
    else $error("channel values changed under a stalled result");

  // a byte that does not end a frame gives its result in the next cycle
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !last_byte) |=> (out_valid && !frame_done))
    else $error("missing result after a mid-frame byte");

endmodule

`default_nettype wire

[sim/rc_satellite_frame_decoder_checker.sv]
// ----------------------------------------------------------------------------
// rc_satellite_frame_decoder_checker
// Watches the configuration, byte and result channels of the frame decoder.
// Every byte transfer runs through a local model of the decoder state
// (byte position, last timestamp, frame bytes, channel values, thresholds).
// The channel snapshot that the model produces is queued, and each result
// transfer is compared field by field with the oldest queued snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_satellite_frame_decoder_checker
  import rcsfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAP_W-1:0]     cfg_data,

  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic [STAMP_W-1:0]   now_ms,

  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [VALUE_W-1:0]   chan0,
  input  logic [VALUE_W-1:0]   chan1,
  input  logic [VALUE_W-1:0]   chan2,
  input  logic [VALUE_W-1:0]   chan3,
  input  logic [VALUE_W-1:0]   chan4,
  input  logic [VALUE_W-1:0]   chan5,
  input  logic [VALUE_W-1:0]   chan6,
  input  logic                 frame_done,
  input  logic                 gap_error,

  output int                   fail_count,
  output int                   open_reports
);

  typedef struct packed {
    logic [OUT_CHANS-1:0][VALUE_W-1:0] chan;
    logic                              done;
    logic                              gap_err;
  } chan_report_t;

  logic [BYTE_W-1:0]                 frame_mem [FRAME_LEN_DEF];
  int unsigned                       fill_pos;
  logic [STAMP_W-1:0]                prev_stamp;
  logic [OUT_CHANS-1:0][VALUE_W-1:0] chan_vals;
  logic [GAP_W-1:0]                  frame_gap;
  logic [GAP_W-1:0]                  loss_gap;
  chan_report_t                      decoded_reports [$];

  logic [OUT_CHANS-1:0][VALUE_W-1:0] got_chan;

  assign got_chan = {chan6, chan5, chan4, chan3, chan2, chan1, chan0};

  function automatic chan_report_t advance_decoder(input logic [BYTE_W-1:0]  data,
                                                   input logic [STAMP_W-1:0] stamp);
    chan_report_t     rep;
    logic [STAMP_W-1:0] gap;
    logic [15:0]      word;
    logic [ID_W-1:0]  id;
    rep = '0;
    gap = stamp - prev_stamp;
    if (gap > STAMP_W'(frame_gap)) begin
      fill_pos = 0;
      if (prev_stamp != '0 && gap > STAMP_W'(loss_gap)) begin
        rep.gap_err = 1'b1;
      end
    end
    frame_mem[fill_pos] = data;
    fill_pos++;
    if (fill_pos >= FRAME_LEN_DEF) begin
      // words from byte 2 on, later words win
      for (int i = 2; i + 1 < FRAME_LEN_DEF; i += 2) begin
        word = {frame_mem[i], frame_mem[i+1]};
        id   = word[VALUE_W +: ID_W];
        if (int'(id) < NUM_CHANNELS_DEF) begin
          chan_vals[id] = word[VALUE_W-1:0];
        end
      end
      fill_pos = 0;
      rep.done = 1'b1;
    end
    prev_stamp = stamp;
    rep.chan   = chan_vals;
    return rep;
  endfunction

  always @(posedge clk) begin
    chan_report_t want;
    int           errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < FRAME_LEN_DEF; i++) begin
        frame_mem[i] = '0;
      end
      fill_pos     = 0;
      prev_stamp   = '0;
      chan_vals    = '0;
      frame_gap    = FRAME_GAP_RST;
      loss_gap     = LOSS_GAP_RST;
      decoded_reports.delete();
      fail_count   <= 0;
      open_reports <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_GAP: frame_gap = cfg_data;
          CFG_LOSS_GAP:  loss_gap  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (decoded_reports.size() == 0) begin
          $error("result transfer with no expected result");
          errs++;
        end else begin
          want = decoded_reports.pop_front();
          for (int k = 0; k < OUT_CHANS; k++) begin
            if (got_chan[k] !== want.chan[k]) begin
              $error("chan%0d: expected %0d, actual %0d", k, want.chan[k], got_chan[k]);
              errs++;
            end
          end
          if (frame_done !== want.done) begin
            $error("frame_done: expected %0d, actual %0d", want.done, frame_done);
            errs++;
          end
          if (gap_error !== want.gap_err) begin
            $error("gap_error: expected %0d, actual %0d", want.gap_err, gap_error);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decoded_reports.push_back(advance_decoder(rx_byte, now_ms));
      end
      fail_count   <= fail_count + errs;
      open_reports <= decoded_reports.size();
    end
  end

endmodule

[sim/tb_rc_satellite_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_rc_satellite_frame_decoder_core
// Stimulus and verdict for the satellite frame decoder. A short directed run
// covers threshold edges, the first byte after reset, a zero timestamp,
// timestamp wrap and ignored channel ids; then well-formed frames with random
// words, broken frames and noise bytes run under several threshold settings
// and several sender/receiver idle patterns, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rc_satellite_frame_decoder_core;
  import rcsfd_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_AT       = 90;
  localparam int HOLD_CYCLES   = 300;
  localparam int SEGMENT_BYTES = 120;
  localparam int DRAIN_CYCLES  = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  // header bytes, then words: id0 max, id6 zero, id15, id7, id0 again, id3, id5
  localparam logic [0:15][7:0] DIRECTED_FRAME = {8'h00, 8'hFF, 16'h03FF, 16'h1800,
                                                 16'hFFFF, 16'h1C00, 16'h4155,
                                                 16'h8EAA, 16'h1401};

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAP_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte   = '0;
  logic [STAMP_W-1:0]   now_ms    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VALUE_W-1:0]   chan0, chan1, chan2, chan3, chan4, chan5, chan6;
  logic                 frame_done;
  logic                 gap_error;

  int                   fail_count;
  int                   open_reports;
  int                   idle_pct   = 0;
  int                   stall_pct  = 0;
  int                   sent_count = 0;
  int                   hold_left  = 0;
  logic                 hold_used  = 1'b0;
  int                   quiet_cycles = 0;
  logic [STAMP_W-1:0]   stamp_now  = '0;
  logic [GAP_W-1:0]     cur_fg     = FRAME_GAP_RST;
  logic [GAP_W-1:0]     cur_lg     = LOSS_GAP_RST;

  rc_satellite_frame_decoder_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
    .chan4(chan4), .chan5(chan5), .chan6(chan6),
    .frame_done(frame_done), .gap_error(gap_error)
  );

  rc_satellite_frame_decoder_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
    .chan4(chan4), .chan5(chan5), .chan6(chan6),
    .frame_done(frame_done), .gap_error(gap_error),
    .fail_count(fail_count), .open_reports(open_reports)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!hold_used && sent_count >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [STAMP_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    now_ms   <= t;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic emit(input logic [BYTE_W-1:0] b, input logic [STAMP_W-1:0] gap);
    stamp_now = stamp_now + gap;
    send_byte(b, stamp_now);
  endtask

  task automatic send_at(input logic [BYTE_W-1:0] b, input logic [STAMP_W-1:0] t);
    stamp_now = t;
    send_byte(b, t);
  endtask

  // wait until every expected result has had its transfer
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_reports != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_gaps(input logic [GAP_W-1:0] fg, input logic [GAP_W-1:0] lg);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FRAME_GAP;
    cfg_data  <= fg;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_LOSS_GAP;
    cfg_data  <= lg;
    do @(posedge clk); while (!cfg_ready);
    if ($urandom_range(1) != 0) begin
      cfg_index <= ($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
      cfg_data  <= GAP_W'($urandom());
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_fg = fg;
    cur_lg = lg;
  endtask

  function automatic logic [STAMP_W-1:0] break_gap();
    case ($urandom_range(3))
      0:       return STAMP_W'(cur_fg) + 1;
      1:       return STAMP_W'(cur_fg) + 1 + $urandom_range(40);
      2:       return STAMP_W'(cur_fg) + STAMP_W'(cur_lg) + 1 + $urandom_range(300);
      default: return STAMP_W'(cur_fg) + 1 + ($urandom() >> $urandom_range(31, 1));
    endcase
  endfunction

  task automatic send_frame(input int n_bytes);
    logic [BYTE_W-1:0] fbytes [FRAME_LEN_DEF];
    logic [15:0]       word;
    logic [ID_W-1:0]   id;
    fbytes[0] = BYTE_W'($urandom());
    fbytes[1] = BYTE_W'($urandom());
    for (int w = 1; w < FRAME_LEN_DEF / 2; w++) begin
      id = ($urandom_range(99) < 80) ? ID_W'($urandom_range(NUM_CHANNELS_DEF - 1))
                                     : ID_W'($urandom_range(15, NUM_CHANNELS_DEF));
      word = {2'($urandom()), id, VALUE_W'($urandom())};
      fbytes[2*w]   = word[15:8];
      fbytes[2*w+1] = word[7:0];
    end
    for (int k = 0; k < n_bytes; k++) begin
      emit(fbytes[k], (k == 0) ? break_gap() : STAMP_W'($urandom_range(cur_fg, 0)));
    end
  endtask

  task automatic send_noise(input int n_bytes);
    logic [BYTE_W-1:0] b;
    for (int k = 0; k < n_bytes; k++) begin
      b = BYTE_W'($urandom());
      case ($urandom_range(4))
        0:       emit(b, STAMP_W'($urandom_range(cur_fg, 0)));
        1:       emit(b, break_gap());
        2:       emit(b, STAMP_W'($urandom()));
        3:       send_at(b, '0);
        default: emit(b, STAMP_W'(cur_lg) + $urandom_range(2));
      endcase
    end
  endtask

  task automatic run_segment(input int n_bytes);
    int start;
    int pick;
    start = sent_count;
    while (sent_count - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(FRAME_LEN_DEF);
      end else if (pick < 85) begin
        send_frame($urandom_range(FRAME_LEN_DEF - 1, 1));
      end else begin
        send_noise($urandom_range(6, 1));
      end
    end
  endtask

  initial begin
    logic [GAP_W-1:0] fg_set [5];
    logic [GAP_W-1:0] lg_set [5];
    int               slot;
    fg_set = '{8'd0, 8'd255, 8'd255, 8'd0,   FRAME_GAP_RST};
    lg_set = '{8'd0, 8'd255, 8'd0,   8'd255, LOSS_GAP_RST};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first byte after reset never flags a gap
    send_at(8'hA5, 32'd1000);
    // lossy gap opens a frame; in-frame gaps at and below the threshold
    for (int k = 0; k < FRAME_LEN_DEF; k++) begin
      emit(DIRECTED_FRAME[k], (k == 0) ? 32'd30 : ((k % 2) != 0 ? 32'd5 : 32'd0));
    end
    settle();
    // loss threshold below frame threshold
    program_gaps(8'd20, 8'd3);
    emit(8'h11, 32'd10);
    emit(8'h22, 32'd21);
    // zero timestamp, then a gap from zero
    send_at(8'h33, '0);
    emit(8'h44, 32'd200);
    // timestamp wrap
    send_at(8'h55, 32'hFFFF_FFFE);
    emit(8'h66, 32'd5);
    settle();
    program_gaps(8'd0, 8'd0);
    emit(8'h77, 32'd0);
    emit(8'h88, 32'd1);

    for (int ph = 0; ph < 4; ph++) begin
      for (int seg = 0; seg < 2; seg++) begin
        settle();
        case (ph)
          0:       begin idle_pct = 0;  stall_pct = 0;  end
          1:       begin idle_pct = 75; stall_pct = 0;  end
          2:       begin idle_pct = 0;  stall_pct = 75; end
          default: begin idle_pct = 18; stall_pct = 18; end
        endcase
        slot = ph * 2 + seg;
        if (slot < 5) begin
          program_gaps(fg_set[slot], lg_set[slot]);
        end else begin
          program_gaps(GAP_W'($urandom_range(40)), GAP_W'($urandom()));
        end
        run_segment(SEGMENT_BYTES);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rcsfd_pkg.sv
rtl/core/rc_satellite_frame_decoder_core.sv
sim/rc_satellite_frame_decoder_checker.sv
sim/tb_rc_satellite_frame_decoder_core.sv
